### hw/rtl/pps_pkg.sv
// shared types and constants for the priority preemptive scheduler
package pps_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = QIDX_W + 1;
	localparam int ID_W        = 8;
	localparam int PRIO_W      = 6;
	localparam int SLICE_W     = 8;
	localparam int REQ_W       = 3;

	localparam logic [PRIO_W-1:0]  PRIORITY_MAX = PRIO_W'(63);
	localparam logic [ID_W-1:0]    RESET_ID     = ID_W'(1);
	localparam logic [PRIO_W-1:0]  RESET_PRIO   = PRIO_W'(31);
	localparam logic [SLICE_W-1:0] RESET_SLICE  = SLICE_W'(4);

	localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_UNBLOCK = 3'd2;
	localparam logic [REQ_W-1:0] REQ_BLOCK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_YIELD   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_SETPRIO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_EXIT    = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_YIELD,
		ST_INSERT,
		ST_SCAN,
		ST_SHIFT,
		ST_CHECK,
		ST_DISPATCH,
		ST_OUT
	} state_t;

endpackage

### hw/rtl/priority_preemptive_scheduler_top.sv
// priority preemptive scheduler with time slice: sequencer, ready queue and running thread
// Usage:
// - request channel (in_valid/in_ready) carries req_type, thread_id and priority_req;
//   in_ready is high only while the sequencer waits for a new item
// - result channel (out_valid/out_ready) gives one item per request: running thread,
//   its priority, idle flag, switched, ready queue fill and overflow
// - cfg_valid/cfg_data writes the slice length; cfg_ready is always high, write only when quiet
// - sequence: decode, then the output state for a tick without yield or an unused code;
//   an insert adds the insert, scan and shift states, the scan passing up to 15 queue entries;
//   a dispatch, a preemption check and a yield add their own states; then back to idle
// - the insert position is found by one priority comparator stepping through the queue,
//   one entry a cycle, then the entries from that position on shift together
// - reset: thread 1 runs at priority 31, empty queue, slice count 0, slice length 4
// - the result sits in an output register; a new item is taken while it waits, and
//   the sequencer holds in its final state until the register is free
module priority_preemptive_scheduler_top
	import pps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [SLICE_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [ID_W-1:0]    thread_id,
	input  logic [PRIO_W-1:0]  priority_req,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ID_W-1:0]    running_id,
	output logic [PRIO_W-1:0]  running_priority,
	output logic               running_idle,
	output logic               switched,
	output logic [FILL_W-1:0]  ready_count,
	output logic               overflow
);

	state_t state_q, state_d;

	logic [SLICE_W-1:0] slice_len_q;
	logic [REQ_W-1:0]   req_q, req_d;
	logic [ID_W-1:0]    id_q, id_d;
	logic [PRIO_W-1:0]  pr_q, pr_d;
	logic [ID_W-1:0]    ins_id_q, ins_id_d;
	logic [PRIO_W-1:0]  ins_pr_q, ins_pr_d;
	logic [FILL_W-1:0]  pos_q, pos_d;
	logic [FILL_W-1:0]  fill_q, fill_d;
	logic [ID_W-1:0]    cur_id_q, cur_id_d;
	logic [PRIO_W-1:0]  cur_pr_q, cur_pr_d;
	logic               idle_q, idle_d;
	logic [SLICE_W-1:0] slice_q, slice_d;
	logic               drop_q, drop_d;
	logic               moved_q, moved_d;
	logic               yield_q, yield_d;
	logic               out_valid_q, out_valid_d;
	logic               out_load;
	logic               ins_wr;
	logic               pop;
	logic [SLICE_W-1:0] slice_inc;
	state_t             after_ins;

	logic [ID_W-1:0]   ready_ids_q [QUEUE_DEPTH];
	logic [PRIO_W-1:0] ready_prio_q [QUEUE_DEPTH];

	logic [ID_W-1:0]   out_id_q;
	logic [PRIO_W-1:0] out_pr_q;
	logic              out_idle_q;
	logic              out_switched_q;
	logic [FILL_W-1:0] out_fill_q;
	logic              out_overflow_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);

	assign slice_inc = (slice_q != '1) ? slice_q + SLICE_W'(1) : slice_q;

	// where an insert continues once the queue has been updated
	always_comb begin
		if (yield_q) begin
			after_ins = ST_DISPATCH;
		end else if (req_q == REQ_CREATE) begin
			after_ins = ST_CHECK;
		end else begin
			after_ins = ST_OUT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slice_len_q <= RESET_SLICE;
			fill_q      <= '0;
			cur_id_q    <= RESET_ID;
			cur_pr_q    <= RESET_PRIO;
			idle_q      <= 1'b0;
			slice_q     <= '0;
			drop_q      <= 1'b0;
			moved_q     <= 1'b0;
			yield_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			cur_id_q    <= cur_id_d;
			cur_pr_q    <= cur_pr_d;
			idle_q      <= idle_d;
			slice_q     <= slice_d;
			drop_q      <= drop_d;
			moved_q     <= moved_d;
			yield_q     <= yield_d;
			out_valid_q <= out_valid_d;
			pos_q       <= pos_d;
			if (cfg_valid && cfg_ready) begin
				slice_len_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_q    <= req_d;
		id_q     <= id_d;
		pr_q     <= pr_d;
		ins_id_q <= ins_id_d;
		ins_pr_q <= ins_pr_d;
		if (out_load) begin
			out_id_q       <= cur_id_q;
			out_pr_q       <= cur_pr_q;
			out_idle_q     <= idle_q;
			out_switched_q <= moved_q;
			out_fill_q     <= fill_q;
			out_overflow_q <= drop_q;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		id_d        = id_q;
		pr_d        = pr_q;
		ins_id_d    = ins_id_q;
		ins_pr_d    = ins_pr_q;
		pos_d       = pos_q;
		fill_d      = fill_q;
		cur_id_d    = cur_id_q;
		cur_pr_d    = cur_pr_q;
		idle_d      = idle_q;
		slice_d     = slice_q;
		drop_d      = drop_q;
		moved_d     = moved_q;
		yield_d     = yield_q;
		out_valid_d = out_valid_q && !out_ready;
		out_load    = 1'b0;
		ins_wr      = 1'b0;
		pop         = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					req_d   = req_type;
					id_d    = thread_id;
					pr_d    = (priority_req > PRIORITY_MAX) ? PRIORITY_MAX : priority_req;
					drop_d  = 1'b0;
					moved_d = 1'b0;
					yield_d = 1'b0;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (req_q)
					REQ_TICK: begin
						slice_d = slice_inc;
						state_d = (slice_inc >= slice_len_q) ? ST_YIELD : ST_OUT;
					end
					REQ_CREATE, REQ_UNBLOCK: begin
						ins_id_d = id_q;
						ins_pr_d = pr_q;
						state_d  = ST_INSERT;
					end
					REQ_BLOCK, REQ_EXIT: begin
						state_d = ST_DISPATCH;
					end
					REQ_YIELD: begin
						state_d = ST_YIELD;
					end
					REQ_SETPRIO: begin
						if (!idle_q) begin
							cur_pr_d = pr_q;
							state_d  = ST_CHECK;
						end else begin
							state_d = ST_OUT;
						end
					end
					default: begin
						state_d = ST_OUT;
					end
				endcase
			end
			ST_YIELD: begin
				yield_d = 1'b1;
				if (!idle_q) begin
					ins_id_d = cur_id_q;
					ins_pr_d = cur_pr_q;
					state_d  = ST_INSERT;
				end else begin
					state_d = ST_DISPATCH;
				end
			end
			ST_INSERT: begin
				if (fill_q >= FILL_W'(QUEUE_DEPTH)) begin
					drop_d  = 1'b1;
					state_d = after_ins;
				end else begin
					pos_d   = '0;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// walk past entries of higher or equal priority
				if (pos_q < fill_q && ins_pr_q <= ready_prio_q[pos_q[QIDX_W-1:0]]) begin
					pos_d = pos_q + FILL_W'(1);
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				ins_wr  = 1'b1;
				fill_d  = fill_q + FILL_W'(1);
				state_d = after_ins;
			end
			ST_CHECK: begin
				if (!idle_q && fill_q != '0 && cur_pr_q < ready_prio_q[0]) begin
					state_d = ST_YIELD;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DISPATCH: begin
				slice_d = '0;
				if (fill_q == '0) begin
					idle_d   = 1'b1;
					cur_id_d = '0;
					cur_pr_d = '0;
					moved_d  = moved_q || !idle_q;
				end else begin
					idle_d   = 1'b0;
					cur_id_d = ready_ids_q[0];
					cur_pr_d = ready_prio_q[0];
					pop      = 1'b1;
					fill_d   = fill_q - FILL_W'(1);
					moved_d  = moved_q || idle_q || (cur_id_q != ready_ids_q[0]);
				end
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					out_load    = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// queue entries: open a gap at the insert position, or move everything toward the head on a pop
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_entry
		always_ff @(posedge clk) begin
			if (ins_wr) begin
				if (FILL_W'(i) == pos_q) begin
					ready_ids_q[i]  <= ins_id_q;
					ready_prio_q[i] <= ins_pr_q;
				end else if (FILL_W'(i) > pos_q) begin
					if (i > 0) begin
						ready_ids_q[i]  <= ready_ids_q[(i > 0) ? i - 1 : 0];
						ready_prio_q[i] <= ready_prio_q[(i > 0) ? i - 1 : 0];
					end
				end
			end else if (pop) begin
				if (i < QUEUE_DEPTH - 1) begin
					ready_ids_q[i]  <= ready_ids_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
					ready_prio_q[i] <= ready_prio_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign running_id       = out_id_q;
	assign running_priority = out_pr_q;
	assign running_idle     = out_idle_q;
	assign switched         = out_switched_q;
	assign ready_count      = out_fill_q;
	assign overflow         = out_overflow_q;

endmodule

### test/priority_preemptive_scheduler_top_test.sv
// self-checking testbench for the priority preemptive scheduler top level
module priority_preemptive_scheduler_top_test;
	import pps_pkg::*;

	localparam logic [REQ_W-1:0] REQ_NOP = 3'd7;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [REQ_W-1:0]  req;
		logic [ID_W-1:0]   tid;
		logic [PRIO_W-1:0] prio;
	} sched_req_t;

	typedef struct {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic              idle;
		logic              switched;
		logic [FILL_W-1:0] fill;
		logic              overflow;
	} sched_view_t;

	typedef enum {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [SLICE_W-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [REQ_W-1:0]   req_type = '0;
	logic [ID_W-1:0]    thread_id = '0;
	logic [PRIO_W-1:0]  priority_req = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [ID_W-1:0]    running_id;
	logic [PRIO_W-1:0]  running_priority;
	logic               running_idle;
	logic               switched;
	logic [FILL_W-1:0]  ready_count;
	logic               overflow;

	priority_preemptive_scheduler_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.thread_id        (thread_id),
		.priority_req     (priority_req),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.running_id       (running_id),
		.running_priority (running_priority),
		.running_idle     (running_idle),
		.switched         (switched),
		.ready_count      (ready_count),
		.overflow         (overflow)
	);

	always #5 clk = ~clk;

	sched_req_t  req_backlog [$];
	sched_view_t want_views [$];
	int          items_left = 0;
	int          err_count = 0;
	int          cycles = 0;
	logic        quiet = 1'b0;

	// scheduler state as the testbench sees it
	logic [ID_W-1:0]    rq_id   [QUEUE_DEPTH];
	logic [PRIO_W-1:0]  rq_prio [QUEUE_DEPTH];
	int                 rq_fill;
	logic [ID_W-1:0]    run_id;
	logic [PRIO_W-1:0]  run_prio;
	logic               run_idle;
	int                 slice_ticks;
	logic [SLICE_W-1:0] slice_len;
	logic               ins_dropped;
	logic               did_switch;

	task automatic report_error(input string msg);
		$display("ERROR at cycle %0d: %s", cycles, msg);
		err_count++;
	endtask

	function automatic void rq_insert(input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] pr);
		int pos;
		int i;
		pos = 0;
		if (rq_fill >= QUEUE_DEPTH) begin
			ins_dropped = 1'b1;
			return;
		end
		while (pos < rq_fill && pr <= rq_prio[pos])
			pos++;
		for (i = rq_fill; i > pos; i--) begin
			rq_id[i]   = rq_id[i-1];
			rq_prio[i] = rq_prio[i-1];
		end
		rq_id[pos]   = id;
		rq_prio[pos] = pr;
		rq_fill++;
	endfunction

	function automatic void rq_dispatch();
		logic              was_idle;
		logic [ID_W-1:0]   was_id;
		int                i;
		was_idle = run_idle;
		was_id   = run_id;
		if (rq_fill == 0) begin
			run_idle = 1'b1;
			run_id   = '0;
			run_prio = '0;
		end else begin
			run_idle = 1'b0;
			run_id   = rq_id[0];
			run_prio = rq_prio[0];
			for (i = 1; i < rq_fill; i++) begin
				rq_id[i-1]   = rq_id[i];
				rq_prio[i-1] = rq_prio[i];
			end
			rq_fill--;
		end
		slice_ticks = 0;
		if (was_idle != run_idle || (!run_idle && was_id != run_id))
			did_switch = 1'b1;
	endfunction

	function automatic void rq_yield();
		if (!run_idle)
			rq_insert(run_id, run_prio);
		rq_dispatch();
	endfunction

	function automatic logic head_outranks();
		return !run_idle && rq_fill > 0 && run_prio < rq_prio[0];
	endfunction

	function automatic sched_view_t sched_step(input sched_req_t r);
		sched_view_t v;
		ins_dropped = 1'b0;
		did_switch  = 1'b0;
		case (r.req)
		REQ_TICK: begin
			if (slice_ticks < 255)
				slice_ticks++;
			if (slice_ticks >= int'(slice_len))
				rq_yield();
		end
		REQ_CREATE: begin
			rq_insert(r.tid, r.prio);
			if (head_outranks())
				rq_yield();
		end
		REQ_UNBLOCK: rq_insert(r.tid, r.prio);
		REQ_BLOCK, REQ_EXIT: rq_dispatch();
		REQ_YIELD: rq_yield();
		REQ_SETPRIO: begin
			if (!run_idle) begin
				run_prio = r.prio;
				if (head_outranks())
					rq_yield();
			end
		end
		default: ;
		endcase
		v.id       = run_idle ? '0 : run_id;
		v.prio     = run_idle ? '0 : run_prio;
		v.idle     = run_idle;
		v.switched = did_switch;
		v.fill     = FILL_W'(rq_fill);
		v.overflow = ins_dropped;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// a few common levels so that equal priorities meet often
	function automatic logic [PRIO_W-1:0] pick_prio();
		if ($urandom_range(0, 99) < 40) begin
			case ($urandom_range(0, 3))
			0: return '0;
			1: return PRIO_W'(31);
			2: return PRIO_W'(32);
			default: return PRIORITY_MAX;
			endcase
		end
		return PRIO_W'($urandom_range(0, 63));
	endfunction

	function automatic logic [REQ_W-1:0] pick_req(input mix_t mix);
		int c [8];
		int r;
		case (mix)
		MIX_FILL:  c = '{10, 35, 70, 75, 85, 93, 96, 100};
		MIX_DRAIN: c = '{20, 30, 40, 70, 80, 88, 98, 100};
		default:   c = '{25, 40, 55, 67, 77, 89, 95, 100};
		endcase
		r = $urandom_range(0, 99);
		if (r < c[0]) return REQ_TICK;
		if (r < c[1]) return REQ_CREATE;
		if (r < c[2]) return REQ_UNBLOCK;
		if (r < c[3]) return REQ_BLOCK;
		if (r < c[4]) return REQ_YIELD;
		if (r < c[5]) return REQ_SETPRIO;
		if (r < c[6]) return REQ_EXIT;
		return REQ_NOP;
	endfunction

	task automatic push_item(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] tid,
			input logic [PRIO_W-1:0] prio);
		sched_req_t it;
		it.req  = req;
		it.tid  = tid;
		it.prio = prio;
		req_backlog.push_back(it);
		items_left++;
	endtask

	task automatic push_random(input int n, input mix_t mix);
		repeat (n)
			push_item(pick_req(mix), ID_W'($urandom_range(0, 255)), pick_prio());
	endtask

	task automatic settle();
		do
			@(posedge clk);
		while (items_left != 0 || want_views.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_slice(input logic [SLICE_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		slice_len = v;
		cfg_valid <= 1'b0;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_req
		int         gap;
		sched_req_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap = 0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				it.req  = req_type;
				it.tid  = thread_id;
				it.prio = priority_req;
				want_views.push_back(sched_step(it));
				items_left--;
			end
			if (gap > 0) begin
				gap--;
				in_valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				it = req_backlog.pop_front();
				req_type     <= it.req;
				thread_id    <= it.tid;
				priority_req <= it.prio;
				in_valid     <= 1'b1;
				gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : watch_result
		int          stall;
		sched_view_t w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (want_views.size() == 0) begin
					report_error("result item with nothing expected");
				end else begin
					w = want_views.pop_front();
					if (running_id !== w.id)
						report_error($sformatf("running_id %0d, want %0d", running_id, w.id));
					if (running_priority !== w.prio)
						report_error($sformatf("running_priority %0d, want %0d",
							running_priority, w.prio));
					if (running_idle !== w.idle)
						report_error($sformatf("running_idle %0b, want %0b", running_idle, w.idle));
					if (switched !== w.switched)
						report_error($sformatf("switched %0b, want %0b", switched, w.switched));
					if (ready_count !== w.fill)
						report_error($sformatf("ready_count %0d, want %0d", ready_count, w.fill));
					if (overflow !== w.overflow)
						report_error($sformatf("overflow %0b, want %0b", overflow, w.overflow));
				end
				stall = pick_gap();
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		rq_fill     = 0;
		run_id      = RESET_ID;
		run_prio    = RESET_PRIO;
		run_idle    = 1'b0;
		slice_ticks = 0;
		slice_len   = RESET_SLICE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: slice expiry, preemption, equal priorities, idle corner cases
		repeat (4) push_item(REQ_TICK, '0, '0);
		push_item(REQ_CREATE, 8'hFF, PRIORITY_MAX);
		push_item(REQ_CREATE, 8'h00, '0);
		push_item(REQ_UNBLOCK, 8'hAA, PRIORITY_MAX);
		push_item(REQ_UNBLOCK, 8'h55, PRIORITY_MAX);
		push_item(REQ_YIELD, 8'h12, 6'h2A);
		push_item(REQ_SETPRIO, 8'h00, '0);
		push_item(REQ_SETPRIO, 8'hFF, PRIORITY_MAX);
		push_item(REQ_EXIT, 8'h00, '0);
		repeat (5) push_item(REQ_BLOCK, 8'h00, '0);
		push_item(REQ_TICK, 8'hFF, PRIORITY_MAX);
		push_item(REQ_SETPRIO, 8'h01, 6'h15);
		push_item(REQ_YIELD, '0, '0);
		push_item(REQ_CREATE, 8'h07, 6'd40);
		repeat (4) push_item(REQ_TICK, '0, '0);
		push_item(REQ_NOP, 8'hFF, PRIORITY_MAX);
		push_item(REQ_NOP, 8'h00, '0);
		settle();

		write_slice(SLICE_W'(1));
		push_random(60, MIX_EVEN);
		settle();

		// longest slice: a run of ticks long enough to expire it
		write_slice(SLICE_W'(255));
		repeat (256) push_item(REQ_TICK, ID_W'($urandom_range(0, 255)), pick_prio());
		push_random(60, MIX_FILL);
		settle();

		write_slice(SLICE_W'($urandom_range(2, 254)));
		push_random(60, MIX_DRAIN);
		settle();

		write_slice(SLICE_W'($urandom_range(1, 255)));
		quiet = 1'b1;
		push_random(50, MIX_EVEN);
		settle();

		repeat (50) @(posedge clk);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
